>>> src/tknv_pkg.sv
// Shared types and constants for the k-nearest-neighbour label vote block.
// Used by the controller, the datapath and the top level.
package tknv_pkg;

  localparam int MAX_NEIGHBOURS = 8;
  localparam int NUM_CLASSES    = 16;
  localparam int DIST_W         = 16;
  localparam int LABEL_W        = 4;
  localparam int K_W            = 4;
  localparam int VOTE_W         = 4;

  localparam logic [DIST_W-1:0] DIST_EMPTY = {DIST_W{1'b1}};
  localparam logic [K_W-1:0]    K_MAX      = K_W'(MAX_NEIGHBOURS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_VOTE,
    ST_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic insert;     // insert the accepted tile into the buffer
    logic vote_init;  // restart the class sweep
    logic vote_step;  // count one class
    logic finish;     // load the result register and clear the buffer
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic vote_last;  // sweep is at the last class
  } status_t;

endpackage

>>> src/topk_nearest_label_vote.sv
// Top level of the k-nearest-neighbour label vote block.
// Instantiates tknv_ctrl and tknv_dp; depends on tknv_pkg.
//
// Each input transaction is one tile (distance, label, last flag). A tile that
// is not last is taken while idle: a parallel compare-and-shift inserts it
// into the sorted buffer of the k nearest tiles, and the next tile can follow
// in the next cycle. A last tile is inserted, then a sweep counts votes one
// class per cycle over all 16 classes, and a finish step loads the result
// register and clears the buffer: the next tile is taken after the finish
// step, which waits while the previous result has not been taken. The result
// register lets a new query stream in while a result waits on the output.
// Configuration writes are always ready and take effect in the next cycle.
module topk_nearest_label_vote (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [tknv_pkg::K_W-1:0]     neighbours_kept,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [tknv_pkg::DIST_W-1:0]  tile_distance,
  input  logic [tknv_pkg::LABEL_W-1:0] tile_label,
  input  logic                         last_tile,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [tknv_pkg::LABEL_W-1:0] predicted_class,
  output logic [tknv_pkg::VOTE_W-1:0]  winning_votes
);

  tknv_pkg::cmd_t    cmd;
  tknv_pkg::status_t status;

  assign cfg_ready = 1'b1;

  tknv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .last_tile (last_tile),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  tknv_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .neighbours_kept (neighbours_kept),
    .tile_distance   (tile_distance),
    .tile_label      (tile_label),
    .cmd             (cmd),
    .status          (status),
    .predicted_class (predicted_class),
    .winning_votes   (winning_votes)
  );

  // A last tile starts the sweep, so no tile is taken in the next cycle
  a_sweep_blocks_input: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last_tile |=> !in_ready)
    else $error("tile accepted during vote sweep");

  // Vote count never exceeds the buffer depth
  a_votes_bounded: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> winning_votes <= tknv_pkg::VOTE_W'(tknv_pkg::MAX_NEIGHBOURS))
    else $error("winning vote count out of range");

  // A new result appears only when leaving the finish step, never while idle
  a_result_after_sweep: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready && !$past(in_ready))
    else $error("result loaded outside the finish step");

endmodule

>>> src/tknv_ctrl.sv
// Controller state machine: sequences tile insertion, the class sweep and the
// result hand-off. Depends on tknv_pkg.
module tknv_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             last_tile,
  output logic             out_valid,
  input  logic             out_ready,
  output tknv_pkg::cmd_t   cmd,
  input  tknv_pkg::status_t status
);

  tknv_pkg::state_t state, state_next;
  logic out_valid_next;

  // State and output-valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tknv_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next     = state;
    in_ready       = 1'b0;
    cmd            = '0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      tknv_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.insert = in_valid;
        if (in_valid && last_tile) begin
          cmd.vote_init = 1'b1;
          state_next    = tknv_pkg::ST_VOTE;
        end
      end
      tknv_pkg::ST_VOTE: begin
        cmd.vote_step = 1'b1;
        if (status.vote_last) begin
          state_next = tknv_pkg::ST_FINISH;
        end
      end
      tknv_pkg::ST_FINISH: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          cmd.finish     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = tknv_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tknv_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> src/tknv_dp.sv
// Datapath: sorted neighbour buffer with parallel compare-and-shift insert, per-class vote
// counter and result register. Depends on tknv_pkg.
module tknv_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  input  logic [tknv_pkg::K_W-1:0]     neighbours_kept,
  input  logic [tknv_pkg::DIST_W-1:0]  tile_distance,
  input  logic [tknv_pkg::LABEL_W-1:0] tile_label,
  input  tknv_pkg::cmd_t               cmd,
  output tknv_pkg::status_t            status,
  output logic [tknv_pkg::LABEL_W-1:0] predicted_class,
  output logic [tknv_pkg::VOTE_W-1:0]  winning_votes
);

  localparam int N     = tknv_pkg::MAX_NEIGHBOURS;
  localparam int IDX_W = $clog2(N);

  logic [tknv_pkg::K_W-1:0]     k_reg;
  logic [tknv_pkg::K_W-1:0]     k_eff;
  logic [tknv_pkg::DIST_W-1:0]  slot_dist  [N];
  logic [tknv_pkg::LABEL_W-1:0] label [N];
  logic [N-1:0]                 valid;

  logic [tknv_pkg::LABEL_W-1:0] cls;
  logic [tknv_pkg::LABEL_W-1:0] best_cls;
  logic [tknv_pkg::VOTE_W-1:0]  best_votes;
  logic [tknv_pkg::VOTE_W-1:0]  cls_votes;

  logic [N-1:0] in_k;   // slot lies below k
  logic [N-1:0] lt;     // new distance below slot distance
  logic [N-1:0] ge;     // slot at or after the insert position
  logic         keep;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      k_reg <= tknv_pkg::K_W'(1);
    end else if (cfg_valid) begin
      k_reg <= neighbours_kept;
    end
  end

  // Clamp k into 1..MAX_NEIGHBOURS
  always_comb begin
    if (k_reg == '0) begin
      k_eff = tknv_pkg::K_W'(1);
    end else if (k_reg > tknv_pkg::K_MAX) begin
      k_eff = tknv_pkg::K_MAX;
    end else begin
      k_eff = k_reg;
    end
  end

  // Insert position: start of the trailing run of smaller compares below slot k-1
  always_comb begin
    for (int s = 0; s < N; s++) begin
      in_k[s] = tknv_pkg::K_W'(s) < k_eff;
      lt[s]   = tile_distance < slot_dist[s];
    end
    ge[N-1] = 1'b1;
    for (int s = N - 2; s >= 0; s--) begin
      if (tknv_pkg::K_W'(s + 1) >= k_eff) begin
        ge[s] = 1'b1;
      end else begin
        ge[s] = lt[s] && ge[s+1];
      end
    end
    keep = tile_distance < slot_dist[k_eff[IDX_W-1:0] - IDX_W'(1)];
  end

  // Neighbour buffer: insert and shift, or clear after the vote
  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      for (int s = 0; s < N; s++) begin
        slot_dist[s] <= tknv_pkg::DIST_EMPTY;
        label[s]     <= '0;
      end
      valid <= '0;
    end else if (cmd.insert && keep) begin
      for (int s = 0; s < N; s++) begin
        if (in_k[s] && ge[s]) begin
          if (s == 0 || !ge[(s == 0) ? 0 : s - 1]) begin
            slot_dist[s] <= tile_distance;
            label[s]     <= tile_label;
            valid[s]     <= 1'b1;
          end else begin
            slot_dist[s] <= slot_dist[(s == 0) ? 0 : s - 1];
            label[s]     <= label[(s == 0) ? 0 : s - 1];
            valid[s]     <= valid[(s == 0) ? 0 : s - 1];
          end
        end
      end
    end
  end

  // Votes for the class under the sweep
  always_comb begin
    cls_votes = '0;
    for (int s = 0; s < N; s++) begin
      if (in_k[s] && valid[s] && label[s] == cls) begin
        cls_votes = cls_votes + tknv_pkg::VOTE_W'(1);
      end
    end
  end

  // Class sweep; lower class wins ties
  always_ff @(posedge clk) begin
    if (rst || cmd.vote_init) begin
      cls <= '0;
    end else if (cmd.vote_step) begin
      cls <= cls + tknv_pkg::LABEL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.vote_step) begin
      if (cls == '0 || cls_votes > best_votes) begin
        best_votes <= cls_votes;
        best_cls   <= cls;
      end
    end
  end

  assign status.vote_last = (cls == tknv_pkg::LABEL_W'(tknv_pkg::NUM_CLASSES - 1));

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      predicted_class <= best_cls;
      winning_votes   <= best_votes;
    end
  end

endmodule
